>>> hdl/eit_pkg.sv
// ----------------------------------------------------------------------------
// eit_pkg
// Shared types and constants for the expiring ignore table: request and
// response words, command codes and the controller-to-datapath strobes.
// ----------------------------------------------------------------------------
package eit_pkg;

   // Default table depth and field widths
   localparam int ENTRIES_DEF = 16;
   localparam int DATA_W      = 32;
   localparam int CMD_W       = 2;
   localparam int SLOTS_W     = 5;

   // Reset value of the expiry register
   localparam logic [DATA_W-1:0] EXPIRY_RESET = 32'd5000;

   // Command codes (code 3 is unused and changes nothing)
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

   // Request word
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] object_id;
      logic [DATA_W-1:0] now_time;
   } eit_req_type;

   // Response word
   typedef struct packed {
      logic               is_ignored;
      logic [SLOTS_W-1:0] used_slots;
   } eit_rsp_type;

   // Controller strobes to the datapath
   typedef struct packed {
      logic capture;   // latch request and per-entry compares
      logic commit;    // apply table update and load response
   } eit_ctl_type;

endpackage

>>> hdl/eit_ctrl.sv
// ----------------------------------------------------------------------------
// eit_ctrl
// Two-state sequencer: takes a request word, then commits the table update
// once the response register is free. Owns both handshakes.
// ----------------------------------------------------------------------------
module eit_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output eit_pkg::eit_ctl_type ctl
);
   import eit_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   // Strobes
   assign ctl.capture = (state_ff == ST_IDLE) && req_valid;
   assign ctl.commit  = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // State and response-valid register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               if (ctl.commit) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (ctl.commit)     rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

endmodule

>>> hdl/eit_dp.sv
// ----------------------------------------------------------------------------
// eit_dp
// Table lanes, per-lane id and age compares, lowest-slot pick, table update
// and response register.
// ----------------------------------------------------------------------------
module eit_dp #(
   parameter int ENTRIES = eit_pkg::ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  eit_pkg::eit_ctl_type        ctl,
   input  eit_pkg::eit_req_type        req_word,
   input  logic                        csr_write_en,
   input  logic [eit_pkg::DATA_W-1:0]  csr_write_data,
   output eit_pkg::eit_rsp_type        rsp_word
);
   import eit_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] FULL = CW'(ENTRIES);

   // Table lanes
   logic [DATA_W-1:0]  ids_ff   [ENTRIES];
   logic [DATA_W-1:0]  ids_in   [ENTRIES];
   logic [DATA_W-1:0]  times_ff [ENTRIES];
   logic [DATA_W-1:0]  times_in [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [DATA_W-1:0]  expiry_ff;

   // Captured request and compare results
   logic [CMD_W-1:0]   cmd_ff;
   logic [DATA_W-1:0]  id_ff;
   logic [DATA_W-1:0]  now_ff;
   logic [ENTRIES-1:0] eq_ff, eq_in;
   logic [ENTRIES-1:0] live_ff, live_in;

   logic [ENTRIES-1:0] in_range;
   logic [ENTRIES-1:0] vmatch;
   logic [ENTRIES-1:0] freev;
   logic [IW-1:0]      m_idx, f_idx, a_idx;
   logic               hit;
   eit_rsp_type        rsp_ff;

   // Slots below the high-water count
   for (genvar i = 0; i < ENTRIES; i++) begin : g_range
      assign in_range[i] = (CW'(i) < count_ff);
   end

   // Per-lane compares against the incoming word
   always_comb begin
      logic [DATA_W-1:0] age;
      for (int i = 0; i < ENTRIES; i++) begin
         age        = req_word.now_time - times_ff[i];
         eq_in[i]   = (ids_ff[i] == req_word.object_id);
         live_in[i] = valid_ff[i] && (age < expiry_ff);
      end
   end

   assign vmatch = eq_ff & valid_ff & in_range;
   assign freev  = in_range & ~live_ff;
   assign a_idx  = count_ff[IW-1:0];

   // Lowest matching and lowest free slot
   always_comb begin
      m_idx = '0;
      f_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (vmatch[i]) m_idx = IW'(i);
         if (freev[i])  f_idx = IW'(i);
      end
   end

   // Table update
   always_comb begin
      ids_in   = ids_ff;
      times_in = times_ff;
      valid_in = valid_ff;
      count_in = count_ff;
      hit      = 1'b0;
      if (ctl.commit) begin
         case (cmd_ff)
            CMD_ADD: begin
               if (|vmatch) begin
                  times_in[m_idx] = now_ff;
               end else if (|freev) begin
                  ids_in[f_idx]   = id_ff;
                  times_in[f_idx] = now_ff;
                  valid_in[f_idx] = 1'b1;
               end else if (count_ff < FULL) begin
                  ids_in[a_idx]   = id_ff;
                  times_in[a_idx] = now_ff;
                  valid_in[a_idx] = 1'b1;
                  count_in        = count_ff + 1'b1;
               end else begin
                  // full: drop slot 0, shift down, new entry on top
                  for (int i = 0; i < ENTRIES - 1; i++) begin
                     ids_in[i]   = ids_ff[i+1];
                     times_in[i] = times_ff[i+1];
                     valid_in[i] = valid_ff[i+1];
                  end
                  ids_in[ENTRIES-1]   = id_ff;
                  times_in[ENTRIES-1] = now_ff;
                  valid_in[ENTRIES-1] = 1'b1;
               end
            end
            CMD_QUERY: begin
               hit = |(eq_ff & live_ff & in_range);
            end
            CMD_DELETE: begin
               valid_in = valid_ff & ~(eq_ff & in_range);
            end
            default: ;
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         count_ff  <= '0;
         expiry_ff <= EXPIRY_RESET;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         if (csr_write_en) expiry_ff <= csr_write_data;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ids_ff   <= ids_in;
      times_ff <= times_in;
      if (ctl.capture) begin
         cmd_ff  <= req_word.cmd;
         id_ff   <= req_word.object_id;
         now_ff  <= req_word.now_time;
         eq_ff   <= eq_in;
         live_ff <= live_in;
      end
      if (ctl.commit) begin
         rsp_ff.is_ignored <= hit;
         rsp_ff.used_slots <= SLOTS_W'(count_in);
      end
   end

   assign rsp_word = rsp_ff;

endmodule

>>> hdl/expiring_ignore_table.sv
// ----------------------------------------------------------------------------
// expiring_ignore_table
// Table of object ids with time stamps: add/refresh, query for a live
// entry, delete. Entries lapse once their age reaches the expiry register.
// ----------------------------------------------------------------------------
//  channel   ports                              direction
//  request   req_valid / req_ready / req_word   in  (cmd, object_id, now_time)
//  response  rsp_valid / rsp_ready / rsp_word   out (is_ignored, used_slots)
//  config    csr_write_en / csr_write_data      in  (expiry_time)
//
//  One word at a time: accepting a word latches it and all
//  per-entry id and age compares; the commit then picks the slot, updates
//  the table and loads the response register.
//  A held response stalls the update cycle; a new word is taken while a
//  finished response waits. Reset is synchronous; all slots come up free,
//  expiry_time comes up at 5000. No clearing pass.
// ----------------------------------------------------------------------------
module expiring_ignore_table #(
   parameter int ENTRIES = eit_pkg::ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  eit_pkg::eit_req_type       req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output eit_pkg::eit_rsp_type       rsp_word,
   input  logic                       csr_write_en,
   input  logic [eit_pkg::DATA_W-1:0] csr_write_data
);
   import eit_pkg::*;

   eit_ctl_type ctl;

   // Sequencer
   eit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl)
   );

   // Table datapath
   eit_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .req_word       (req_word),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_word       (rsp_word)
   );

`ifndef SYNTH
   // one word in flight: no new word right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("word accepted while previous one still in flight");

   // a commit always presents a response next cycle
   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |=> rsp_valid)
      else $error("commit without response valid");

   // a commit only when the response register can take it
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |-> (!rsp_valid || rsp_ready))
      else $error("pending response overwritten");

   // slot count in a valid response never beyond the table depth (depths up to 31)
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((ENTRIES > 31) || (rsp_word.used_slots <= ENTRIES)))
      else $error("used_slots beyond table depth");
`endif

endmodule
